### rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/cau_pkg.sv
// Types and constants of the complex arithmetic unit
package cau_pkg;
    localparam int unsigned RES_WIDTH = 49;
    localparam int unsigned NUM_WIDTH = 50;
    localparam int unsigned DEN_WIDTH = 50;
    localparam int unsigned QW        = 50;
    localparam int unsigned CNT_STEPS = 64;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

    typedef struct packed {
        logic                 neg_re;
        logic                 neg_im;
        logic                 sat_re;
        logic                 sat_im;
        logic                 dz;
    } t_ctl;
endpackage

### rtl/core/cau_div_cell.sv
// One restoring-division cell: one quotient bit for each of two lanes
module cau_div_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_stall,
    input  logic [cau_pkg::DEN_WIDTH-1:0]       i_den,
    input  logic [cau_pkg::NUM_WIDTH-1:0]       i_rem_re,
    input  logic [cau_pkg::NUM_WIDTH-1:0]       i_rem_im,
    input  logic [cau_pkg::NUM_WIDTH-1:0]       i_num_re,
    input  logic [cau_pkg::NUM_WIDTH-1:0]       i_num_im,
    input  logic [cau_pkg::QW-1:0]              i_q_re,
    input  logic [cau_pkg::QW-1:0]              i_q_im,
    input  cau_pkg::t_ctl                       i_ctl,
    output logic                                o_valid,
    output logic [cau_pkg::DEN_WIDTH-1:0]       o_den,
    output logic [cau_pkg::NUM_WIDTH-1:0]       o_rem_re,
    output logic [cau_pkg::NUM_WIDTH-1:0]       o_rem_im,
    output logic [cau_pkg::NUM_WIDTH-1:0]       o_num_re,
    output logic [cau_pkg::NUM_WIDTH-1:0]       o_num_im,
    output logic [cau_pkg::QW-1:0]              o_q_re,
    output logic [cau_pkg::QW-1:0]              o_q_im,
    output cau_pkg::t_ctl                       o_ctl
);
    logic [cau_pkg::NUM_WIDTH:0] sh_re, sh_im, df_re, df_im;
    logic                        ge_re, ge_im;

    always_comb begin
        sh_re = {i_rem_re, i_num_re[cau_pkg::NUM_WIDTH-1]};
        sh_im = {i_rem_im, i_num_im[cau_pkg::NUM_WIDTH-1]};
        df_re = sh_re - {1'b0, i_den};
        df_im = sh_im - {1'b0, i_den};
        ge_re = !df_re[cau_pkg::NUM_WIDTH];
        ge_im = !df_im[cau_pkg::NUM_WIDTH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (!i_stall) begin
            o_valid <= i_valid;
        end
        if (!i_stall) begin
            o_den    <= i_den;
            o_rem_re <= ge_re ? df_re[cau_pkg::NUM_WIDTH-1:0] : sh_re[cau_pkg::NUM_WIDTH-1:0];
            o_rem_im <= ge_im ? df_im[cau_pkg::NUM_WIDTH-1:0] : sh_im[cau_pkg::NUM_WIDTH-1:0];
            o_num_re <= {i_num_re[cau_pkg::NUM_WIDTH-2:0], 1'b0};
            o_num_im <= {i_num_im[cau_pkg::NUM_WIDTH-2:0], 1'b0};
            o_q_re   <= {i_q_re[cau_pkg::QW-2:0], ge_re};
            o_q_im   <= {i_q_im[cau_pkg::QW-2:0], ge_im};
            o_ctl    <= i_ctl;
        end
    end
endmodule

### rtl/core/complex_arith_unit_core.sv
// Top level of the complex arithmetic unit
//
// Complex add, subtract, multiply and divide on signed integer operands.
// Input channel: i_valid / o_stall with i_func, i_a_re, i_a_im, i_b_re,
// i_b_im. Output channel: o_valid / i_stall with o_res_re, o_res_im,
// o_div_by_zero. One result beat leaves for every input beat, in order.
// Throughput: one beat per cycle while the receiver does not stall. Each
// beat passes three front stages and then the chain of division cells
// on its way to the output register, each cell producing one quotient
// bit of both lanes.
// Add, subtract and multiply travel the same chain so order is kept.
// Front stages: operand capture, products, numerator and denominator
// forming, then the cell chain, then saturation and sign into the
// output register.
// The whole pipe advances as one; when the receiver stalls an output
// beat every stage holds and o_stall rises, so nothing is dropped.
// Reset (synchronous, active low) clears all valid flags; the pipe
// comes out empty and takes a beat on the next cycle.
`include "assert_macros.svh"
module complex_arith_unit_core #(
    parameter int OPERAND_WIDTH = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_func,
    input  logic signed [15:0]             i_a_re,
    input  logic signed [15:0]             i_a_im,
    input  logic signed [15:0]             i_b_re,
    input  logic signed [15:0]             i_b_im,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [cau_pkg::RES_WIDTH-1:0] o_res_re,
    output logic signed [cau_pkg::RES_WIDTH-1:0] o_res_im,
    output logic                           o_div_by_zero
);
    localparam int NW = cau_pkg::NUM_WIDTH;
    localparam int N  = cau_pkg::NUM_WIDTH;
    localparam logic [NW-1:0] LIMIT = NW'(64'd1 << 47);

    // whole pipe advances together
    logic adv;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // stage 1: sign-extend operands from OPERAND_WIDTH bits
    logic                 r1_v;
    cau_pkg::t_func       r1_func;
    logic signed [24:0]   r1_ar, r1_ai, r1_br, r1_bi;

    function automatic logic signed [24:0] sext(input logic [15:0] raw);
        logic [23:0] w;
        logic [23:0] m;
        w = {8'd0, raw};
        m = (24'd1 << OPERAND_WIDTH) - 24'd1;
        w = w & m;
        if (w[OPERAND_WIDTH-1]) begin
            return $signed({1'b0, w}) - $signed(25'(25'd1 << OPERAND_WIDTH));
        end
        return $signed({1'b0, w});
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
        end
        if (adv) begin
            r1_func <= cau_pkg::t_func'(i_func);
            r1_ar   <= sext(i_a_re);
            r1_ai   <= sext(i_a_im);
            r1_br   <= sext(i_b_re);
            r1_bi   <= sext(i_b_im);
        end
    end

    // stage 2: products (25x25) and sums
    logic               r2_v;
    cau_pkg::t_func     r2_func;
    logic signed [48:0] r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;
    logic signed [25:0] r2_s_re, r2_s_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
        end
        if (adv) begin
            r2_func <= r1_func;
            r2_p0 <= 49'(r1_ar * r1_br);
            r2_p1 <= 49'(r1_ai * r1_bi);
            r2_p2 <= 49'(r1_ar * r1_bi);
            r2_p3 <= 49'(r1_ai * r1_br);
            r2_p4 <= 49'(r1_br * r1_br);
            r2_p5 <= 49'(r1_bi * r1_bi);
            r2_s_re <= (r1_func == cau_pkg::FUNC_SUB) ? 26'(r1_ar) - 26'(r1_br)
                                                       : 26'(r1_ar) + 26'(r1_br);
            r2_s_im <= (r1_func == cau_pkg::FUNC_SUB) ? 26'(r1_ai) - 26'(r1_bi)
                                                       : 26'(r1_ai) + 26'(r1_bi);
        end
    end

    // stage 3: pick value; divide lanes get |num| and den, others den=1 with
    // the integer value so the chain returns it unchanged
    logic               r3_v;
    logic signed [NW-1:0] v_re, v_im;
    logic [NW-1:0]      m_re, m_im, den;
    logic               dz, isdiv;
    cau_pkg::t_ctl      ctl3;
    logic [NW-1:0]      r3_num_re, r3_num_im, r3_den;
    cau_pkg::t_ctl      r3_ctl;

    always_comb begin
        isdiv = (r2_func == cau_pkg::FUNC_DIV);
        case (r2_func)
            cau_pkg::FUNC_ADD, cau_pkg::FUNC_SUB: begin
                v_re = NW'(r2_s_re);
                v_im = NW'(r2_s_im);
            end
            cau_pkg::FUNC_MUL: begin
                v_re = NW'(r2_p0) - NW'(r2_p1);
                v_im = NW'(r2_p2) + NW'(r2_p3);
            end
            default: begin
                v_re = NW'(r2_p0) + NW'(r2_p1);
                v_im = NW'(r2_p3) - NW'(r2_p2);
            end
        endcase
        den  = NW'($unsigned(r2_p4)) + NW'($unsigned(r2_p5));
        dz   = isdiv && (den == '0);
        m_re = v_re[NW-1] ? NW'(-v_re) : NW'(v_re);
        m_im = v_im[NW-1] ? NW'(-v_im) : NW'(v_im);
        ctl3.neg_re = v_re[NW-1];
        ctl3.neg_im = v_im[NW-1];
        ctl3.dz     = dz;
        // non-divide: saturate if |v| << FRAC_BITS would exceed the limit
        ctl3.sat_re = !isdiv && (m_re > (LIMIT >> FRAC_BITS));
        ctl3.sat_im = !isdiv && (m_im > (LIMIT >> FRAC_BITS));
    end

    // the numerator enters shifted by FRAC_BITS, so the chain's integer
    // quotient is the fixed-point result truncated toward zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv) begin
            r3_v <= r2_v;
        end
        if (adv) begin
            r3_num_re <= dz ? '0 : (m_re << FRAC_BITS);
            r3_num_im <= dz ? '0 : (m_im << FRAC_BITS);
            r3_den    <= isdiv ? (dz ? NW'(1) : den) : NW'(1);
            r3_ctl    <= ctl3;
        end
    end

    // cell chain: N restoring steps give floor(|num|/den) exactly
    logic                v_c  [N+1];
    logic [NW-1:0]       dn_c [N+1];
    logic [NW-1:0]       rr_c [N+1];
    logic [NW-1:0]       ri_c [N+1];
    logic [NW-1:0]       nr_c [N+1];
    logic [NW-1:0]       ni_c [N+1];
    logic [NW-1:0]       qr_c [N+1];
    logic [NW-1:0]       qi_c [N+1];
    cau_pkg::t_ctl       ct_c [N+1];

    assign v_c[0]  = r3_v;
    assign dn_c[0] = r3_den;
    assign rr_c[0] = '0;
    assign ri_c[0] = '0;
    assign nr_c[0] = r3_num_re;
    assign ni_c[0] = r3_num_im;
    assign qr_c[0] = '0;
    assign qi_c[0] = '0;
    assign ct_c[0] = r3_ctl;

    for (genvar g = 0; g < N; g++) begin : g_cell
        cau_div_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (v_c[g]),
            .i_stall  (!adv),
            .i_den    (dn_c[g]),
            .i_rem_re (rr_c[g]),
            .i_rem_im (ri_c[g]),
            .i_num_re (nr_c[g]),
            .i_num_im (ni_c[g]),
            .i_q_re   (qr_c[g]),
            .i_q_im   (qi_c[g]),
            .i_ctl    (ct_c[g]),
            .o_valid  (v_c[g+1]),
            .o_den    (dn_c[g+1]),
            .o_rem_re (rr_c[g+1]),
            .o_rem_im (ri_c[g+1]),
            .o_num_re (nr_c[g+1]),
            .o_num_im (ni_c[g+1]),
            .o_q_re   (qr_c[g+1]),
            .o_q_im   (qi_c[g+1]),
            .o_ctl    (ct_c[g+1])
        );
    end

    // output stage: saturate and apply sign
    logic [NW-1:0] q_re, q_im;
    logic          sr, si;
    always_comb begin
        q_re = qr_c[N];
        q_im = qi_c[N];
        sr = ct_c[N].sat_re || (q_re > LIMIT);
        si = ct_c[N].sat_im || (q_im > LIMIT);
        if (sr) q_re = LIMIT;
        if (si) q_im = LIMIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= v_c[N];
        end
        if (adv) begin
            o_res_re <= ct_c[N].neg_re ? -$signed(q_re[cau_pkg::RES_WIDTH-1:0])
                                       : $signed(q_re[cau_pkg::RES_WIDTH-1:0]);
            o_res_im <= ct_c[N].neg_im ? -$signed(q_im[cau_pkg::RES_WIDTH-1:0])
                                       : $signed(q_im[cau_pkg::RES_WIDTH-1:0]);
            o_div_by_zero <= ct_c[N].dz;
        end
    end

    `ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid)
    `ASSERT_IMPL(a_dz_zero, i_clk, i_rst_n, o_valid && o_div_by_zero, o_res_re == '0)
endmodule

### tb/complex_arith_unit_core_tb.sv
// Self-checking testbench for the complex arithmetic unit core
module complex_arith_unit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RW         = cau_pkg::RES_WIDTH;
    localparam int FRAC       = 16;
    localparam int LAT        = 60;     // pipe depth plus margin
    localparam int STALL_LIM  = 5000;   // cycles with no beat on either side
    localparam int HOLD_LEN   = 400;    // long receiver hold-off
    localparam int N_RANDOM   = 1630;

    typedef struct {
        bit signed [RW-1:0] re;
        bit signed [RW-1:0] im;
        bit                 dz;
    } t_cres;

    typedef struct {
        cau_pkg::t_func     fn;
        shortint            ar, ai, br, bi;
        bit                 typed;  // expected value given in the row
        t_cres              want;
    } t_row;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_valid = 0;
    logic                 o_stall;
    logic [1:0]           i_func = cau_pkg::FUNC_ADD;
    logic signed [15:0]   i_a_re = 0, i_a_im = 0, i_b_re = 0, i_b_im = 0;
    logic                 o_valid;
    logic                 i_stall = 0;
    logic signed [RW-1:0] o_res_re, o_res_im;
    logic                 o_div_by_zero;

    complex_arith_unit_core DUT (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    t_cres result_q[$];
    int    mismatches = 0;
    int    n_sent = 0, n_got = 0, n_dz = 0;
    int    send_idle_pct = 0, recv_stall_pct = 0;
    int    hold_req = 0;        // bumped by the stimulus to ask for a hold-off
    int    idle_cycles = 0;

    // Saturate a magnitude and apply the sign, in result width
    function automatic bit signed [RW-1:0] signed_sat(bit neg, longint unsigned mag);
        longint unsigned lim = 64'd1 << 47;
        longint unsigned m = (mag > lim) ? lim : mag;
        longint unsigned v = neg ? -m : m;
        return v[RW-1:0];
    endfunction

    // Integer to fixed point
    function automatic bit signed [RW-1:0] int_to_fix(longint v);
        longint unsigned m = (v < 0) ? -v : v;
        if (m > ((64'd1 << 47) >> FRAC)) m = 64'd1 << 47;
        else m = m << FRAC;
        return signed_sat(v < 0, m);
    endfunction

    // Long division to FRAC fraction bits, truncated toward zero
    function automatic bit signed [RW-1:0] fix_quot(longint num, longint unsigned den);
        longint unsigned lim = 64'd1 << 47;
        longint unsigned m = (num < 0) ? -num : num;
        longint unsigned q = m / den;
        longint unsigned r = m % den;
        if (q > lim) return signed_sat(num < 0, lim);
        for (int i = 0; i < FRAC; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
            if (q > lim) return signed_sat(num < 0, lim);
        end
        return signed_sat(num < 0, q);
    endfunction

    function automatic t_cres complex_result(cau_pkg::t_func fn, longint ar, longint ai,
                                             longint br, longint bi);
        t_cres r = '{0, 0, 0};
        longint unsigned den;
        case (fn)
            cau_pkg::FUNC_ADD: begin
                r.re = int_to_fix(ar + br);
                r.im = int_to_fix(ai + bi);
            end
            cau_pkg::FUNC_SUB: begin
                r.re = int_to_fix(ar - br);
                r.im = int_to_fix(ai - bi);
            end
            cau_pkg::FUNC_MUL: begin
                r.re = int_to_fix(ar * br - ai * bi);
                r.im = int_to_fix(ar * bi + ai * br);
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) r.dz = 1;
                else begin
                    r.re = fix_quot(ar * br + ai * bi, den);
                    r.im = fix_quot(ai * br - ar * bi, den);
                end
            end
        endcase
        return r;
    endfunction

    // Offer one beat, idling first at random; record the expectation on acceptance
    task automatic send_beat(cau_pkg::t_func fn, shortint ar, shortint ai, shortint br,
                             shortint bi, bit typed, t_cres want);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_func  <= fn;
        i_a_re  <= ar;
        i_a_im  <= ai;
        i_b_re  <= br;
        i_b_im  <= bi;
        do @(posedge i_clk); while (o_stall);
        result_q.push_back(typed ? want : complex_result(fn, ar, ai, br, bi));
        n_sent++;
    endtask

    function automatic shortint rand_operand();
        case ($urandom_range(9))
            0:       return shortint'(-32768);
            1:       return shortint'(32767);
            2:       return shortint'(0);
            3, 4:    return shortint'(int'($urandom_range(15)) - 7);
            5:       return shortint'(int'($urandom_range(511)) - 256);
            default: return shortint'($urandom);
        endcase
    endfunction

    task automatic wait_drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: check each result beat, then choose the next stall
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                n_got++;
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result beat with nothing expected re=%0d im=%0d",
                                 o_res_re, o_res_im);
                end else begin
                    t_cres w;
                    w = result_q.pop_front();
                    if (w.dz) n_dz++;
                    if (o_res_re !== w.re || o_res_im !== w.im || o_div_by_zero !== w.dz) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: beat %0d expected re=%0d im=%0d dz=%0b, got re=%0d im=%0d dz=%0b",
                                     n_got, w.re, w.im, w.dz, o_res_re, o_res_im, o_div_by_zero);
                    end
                end
            end
            // load a fresh hold-off when asked, else stall at random
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1;
            end else begin
                i_stall <= (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIM) begin
            $display("ERROR: no progress for %0d cycles", STALL_LIM);
            $display("complex_arith_unit_core_tb failed");
            $finish;
        end
    end

    // Directed rows: extremes, every operation, divide by zero
    t_row rows[22] = '{
        '{cau_pkg::FUNC_ADD, 0, 0, 0, 0, 1, '{0, 0, 0}},
        '{cau_pkg::FUNC_ADD, 32767, 32767, 32767, 32767, 1,
          '{49'sd4294836224, 49'sd4294836224, 0}},
        '{cau_pkg::FUNC_ADD, -32768, -32768, -32768, -32768, 1,
          '{-49'sd4294967296, -49'sd4294967296, 0}},
        '{cau_pkg::FUNC_SUB, 32767, -32768, -32768, 32767, 0, '{0, 0, 0}},
        '{cau_pkg::FUNC_SUB, -32768, 32767, 32767, -32768, 0, '{0, 0, 0}},
        '{cau_pkg::FUNC_SUB, 5, -3, 5, -3, 1, '{0, 0, 0}},
        '{cau_pkg::FUNC_MUL, -32768, 0, -32768, 0, 1, '{49'sd70368744177664, 0, 0}},
        '{cau_pkg::FUNC_MUL, -32768, -32768, -32768, 32767, 0, '{0, 0, 0}},
        '{cau_pkg::FUNC_MUL, 32767, 32767, 32767, -32768, 0, '{0, 0, 0}},
        '{cau_pkg::FUNC_MUL, -32768, 32767, -32768, 32767, 0, '{0, 0, 0}},
        '{cau_pkg::FUNC_MUL, 3, 4, 3, -4, 0, '{0, 0, 0}},
        '{cau_pkg::FUNC_DIV, 1234, -77, 0, 0, 1, '{0, 0, 1}},
        '{cau_pkg::FUNC_DIV, -32768, -32768, 0, 0, 1, '{0, 0, 1}},
        '{cau_pkg::FUNC_DIV, 1, 0, 1, 0, 1, '{49'sd65536, 0, 0}},
        '{cau_pkg::FUNC_DIV, 1, 0, 3, 0, 0, '{0, 0, 0}},
        '{cau_pkg::FUNC_DIV, -1, 0, 3, 0, 0, '{0, 0, 0}},
        '{cau_pkg::FUNC_DIV, -32768, -32768, 1, 0, 0, '{0, 0, 0}},
        '{cau_pkg::FUNC_DIV, 32767, -32768, 0, 1, 0, '{0, 0, 0}},
        '{cau_pkg::FUNC_DIV, 1, 1, -32768, -32768, 0, '{0, 0, 0}},
        '{cau_pkg::FUNC_DIV, -32768, 32767, 32767, -32768, 0, '{0, 0, 0}},
        '{cau_pkg::FUNC_DIV, 7, -5, -1, 2, 0, '{0, 0, 0}},
        '{cau_pkg::FUNC_DIV, 0, 0, 32767, 32767, 1, '{0, 0, 0}}
    };

    int pcts[4][2] = '{'{0, 0}, '{73, 0}, '{0, 73}, '{16, 16}};

    initial begin
        t_cres none;
        cau_pkg::t_func fn;
        shortint br, bi;
        none = '{0, 0, 0};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (rows[k])
            send_beat(rows[k].fn, rows[k].ar, rows[k].ai, rows[k].br, rows[k].bi,
                      rows[k].typed, rows[k].want);
        wait_drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = pcts[ph][0];
            recv_stall_pct = pcts[ph][1];
            // long hold-off at the start of the first phase: fill the pipe to stall
            if (ph == 0) hold_req++;
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                fn = cau_pkg::t_func'($urandom_range(3));
                br = rand_operand();
                bi = rand_operand();
                if (fn == cau_pkg::FUNC_DIV && $urandom_range(15) == 0) begin
                    br = 0;
                    bi = 0;
                end
                send_beat(fn, rand_operand(), rand_operand(), br, bi, 0, none);
            end
            // pause the sender until every result is back
            wait_drain();
        end

        repeat (LAT) @(posedge i_clk);
        if (result_q.size() != 0) mismatches++;
        $display("Run covered %0d beats in, %0d results out (%0d divide-by-zero),",
                 n_sent, n_got, n_dz);
        $display("over four idle/stall mixes and one long receiver hold-off; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("complex_arith_unit_core_tb passed");
        else
            $display("complex_arith_unit_core_tb failed");
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/cau_pkg.sv
rtl/core/cau_div_cell.sv
rtl/core/complex_arith_unit_core.sv
tb/complex_arith_unit_core_tb.sv
